### rtl/assert_macros.svh
// Assertion macros shared by the hexahedron split RTL.
// Include with the bare file name; SYNTH empties every macro for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising edge outside of reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside of reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### rtl/hts_pkg.sv
// Shared types, constants and corner tables for the hexahedron split.
// No dependencies; every RTL module imports this package.
package hts_pkg;

   // id width kept inside the block; ports stay FIELD_W wide
   localparam int unsigned ID_BITS = 32;
   localparam int unsigned FIELD_W = 32;
   localparam int unsigned ID_W    = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;

   typedef logic [ID_W-1:0]         id_type;
   typedef logic [7:0][ID_W-1:0]    hex_type;
   typedef logic [7:0][FIELD_W-1:0] port_hex_type;
   typedef logic [2:0]              corner_type;
   typedef logic [2:0]              tet_idx_type;
   typedef logic [1:0]              split_type;
   typedef logic [2:0]              pattern_type;

   // diagonal patterns that call for a rotation about the v0-v6 axis
   localparam pattern_type PAT_ROT120_LO = 3'b001;
   localparam pattern_type PAT_ROT120_HI = 3'b110;
   localparam pattern_type PAT_ROT240_LO = 3'b010;
   localparam pattern_type PAT_ROT240_HI = 3'b101;

   // split count that gives five tetrahedra, and last tet index per size
   localparam split_type   SPLIT_FIVE    = 2'd0;
   localparam tet_idx_type LAST_TET_FIVE = 3'd4;
   localparam tet_idx_type LAST_TET_SIX  = 3'd5;

   // corner permutation that brings the smallest-id corner to position 0
   localparam corner_type PERM_TAB [8][8] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
      '{3'd1, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6},
      '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
      '{3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6},
      '{3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6},
      '{3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7},
      '{3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4},
      '{3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5}
   };

   // tetrahedra in local corner positions, one table per split count
   localparam corner_type TET_TAB [4][6][4] = '{
      '{'{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd2, 3'd7, 3'd5}, '{3'd0, 3'd2, 3'd3, 3'd7},
        '{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd2, 3'd7, 3'd5, 3'd6}, '{3'd0, 3'd0, 3'd0, 3'd0}},
      '{'{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd0, 3'd1, 3'd7, 3'd5}, '{3'd1, 3'd6, 3'd7, 3'd5},
        '{3'd0, 3'd7, 3'd2, 3'd3}, '{3'd0, 3'd7, 3'd1, 3'd2}, '{3'd1, 3'd7, 3'd6, 3'd2}},
      '{'{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
        '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd3, 3'd6, 3'd2}, '{3'd0, 3'd6, 3'd5, 3'd2}},
      '{'{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
        '{3'd0, 3'd5, 3'd6, 3'd4}, '{3'd1, 3'd5, 3'd6, 3'd0}, '{3'd1, 3'd6, 3'd2, 3'd0}}
   };

   // hexahedron after the minimum search
   typedef struct packed {
      logic       valid;
      corner_type min_idx;
      hex_type    verts;
   } minsel_type;

   // hexahedron in canonical orientation with its split count
   typedef struct packed {
      hex_type   verts;
      split_type split;
   } canon_type;

endpackage

### rtl/hts_minsel.sv
// Request register and smallest-id corner search (two register stages).
// Depends on hts_pkg.
module hts_minsel
   import hts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  port_hex_type req_verts,
   output logic         busy,
   input  logic         down_ready,
   output minsel_type   stage
);

   logic       in_valid_ff, in_valid_in;
   hex_type    in_verts_ff, in_verts_in;
   logic       out_valid_ff, out_valid_in;
   corner_type out_min_ff;
   hex_type    out_verts_ff;

   logic       out_free;
   logic       accept;
   id_type     val1 [4];
   corner_type idx1 [4];
   id_type     val2 [2];
   corner_type idx2 [2];
   corner_type min_idx;

   // hand off to the next stage when it is empty or draining
   assign out_free = !out_valid_ff || down_ready;
   assign busy     = in_valid_ff && !out_free;
   assign accept   = start && !busy;

   // truncate incoming ids to the working width
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         in_verts_in[i] = id_type'(req_verts[i]);
      end
   end

   assign in_valid_in  = accept ? 1'b1 : (out_free ? 1'b0 : in_valid_ff);
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   // find the first smallest id; a higher corner wins only when strictly less
   always_comb begin
      for (int p = 0; p < 4; p++) begin
         if (in_verts_ff[2*p+1] < in_verts_ff[2*p]) begin
            val1[p] = in_verts_ff[2*p+1];
            idx1[p] = corner_type'(2*p+1);
         end else begin
            val1[p] = in_verts_ff[2*p];
            idx1[p] = corner_type'(2*p);
         end
      end
      for (int q = 0; q < 2; q++) begin
         if (val1[2*q+1] < val1[2*q]) begin
            val2[q] = val1[2*q+1];
            idx2[q] = idx1[2*q+1];
         end else begin
            val2[q] = val1[2*q];
            idx2[q] = idx1[2*q];
         end
      end
      min_idx = (val2[1] < val2[0]) ? idx2[1] : idx2[0];
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture the request and advance it with its minimum corner
   always_ff @(posedge clock) begin
      if (accept) begin
         in_verts_ff <= in_verts_in;
      end
      if (out_free && in_valid_ff) begin
         out_verts_ff <= in_verts_ff;
         out_min_ff   <= min_idx;
      end
   end

   assign stage.valid   = out_valid_ff;
   assign stage.min_idx = out_min_ff;
   assign stage.verts   = out_verts_ff;

endmodule

### rtl/hts_canon.sv
// Permutation, diagonal comparisons and rotation into canonical orientation.
// Combinational; depends on hts_pkg.
module hts_canon
   import hts_pkg::*;
(
   input  minsel_type stage,
   output canon_type  canon
);

   hex_type     perm;
   hex_type     rot;
   pattern_type bits;

   // bring the smallest-id corner to position 0
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         perm[i] = stage.verts[PERM_TAB[stage.min_idx][i]];
      end
   end

   // compare the min of one diagonal against the min of the other per far face
   always_comb begin
      bits[2] = ((perm[1] < perm[6]) ? perm[1] : perm[6]) <
                ((perm[2] < perm[5]) ? perm[2] : perm[5]);
      bits[1] = ((perm[3] < perm[6]) ? perm[3] : perm[6]) <
                ((perm[2] < perm[7]) ? perm[2] : perm[7]);
      bits[0] = ((perm[4] < perm[6]) ? perm[4] : perm[6]) <
                ((perm[5] < perm[7]) ? perm[5] : perm[7]);
   end

   // rotate about the v0-v6 axis when the pattern asks for it
   always_comb begin
      rot = perm;
      case (bits) inside
         PAT_ROT120_LO, PAT_ROT120_HI: begin
            rot[1] = perm[4];
            rot[4] = perm[3];
            rot[3] = perm[1];
            rot[5] = perm[7];
            rot[7] = perm[2];
            rot[2] = perm[5];
         end
         PAT_ROT240_LO, PAT_ROT240_HI: begin
            rot[1] = perm[3];
            rot[3] = perm[4];
            rot[4] = perm[1];
            rot[5] = perm[2];
            rot[2] = perm[7];
            rot[7] = perm[5];
         end
         default: begin
            rot = perm;
         end
      endcase
   end

   assign canon.verts = rot;
   assign canon.split = split_type'({1'b0, bits[2]} + {1'b0, bits[1]} + {1'b0, bits[0]});

endmodule

### rtl/hts_emit.sv
// Holding register and tetrahedron sequencer with the result register.
// Depends on hts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hts_emit
   import hts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  canon_type   canon,
   output logic        in_ready,
   output logic        rsp_strobe,
   output logic [31:0] rsp_corner_a,
   output logic [31:0] rsp_corner_b,
   output logic [31:0] rsp_corner_c,
   output logic [31:0] rsp_corner_d,
   output tet_idx_type rsp_tet_number,
   output split_type   rsp_split_case,
   output logic        rsp_last_tet
);

   logic        hold_valid_ff, hold_valid_in;
   hex_type     hold_verts_ff;
   split_type   hold_split_ff;
   tet_idx_type tet_ff, tet_in;

   logic        strobe_ff;
   logic [31:0] corner_a_ff, corner_b_ff, corner_c_ff, corner_d_ff;
   tet_idx_type tet_number_ff;
   split_type   split_case_ff;
   logic        last_tet_ff;

   tet_idx_type last_idx;
   logic        last_now;
   logic        load;

   // finish the current hexahedron on its last tetrahedron
   assign last_idx = (hold_split_ff == SPLIT_FIVE) ? LAST_TET_FIVE : LAST_TET_SIX;
   assign last_now = hold_valid_ff && (tet_ff == last_idx);
   assign in_ready = !hold_valid_ff || last_now;
   assign load     = in_ready && in_valid;

   assign hold_valid_in = load ? 1'b1 : (last_now ? 1'b0 : hold_valid_ff);
   assign tet_in        = load ? '0 : tet_idx_type'(tet_ff + 3'd1);

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         tet_ff        <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         tet_ff        <= tet_in;
         strobe_ff     <= hold_valid_ff;
      end
   end

   // load the next hexahedron and drive one tetrahedron per cycle
   always_ff @(posedge clock) begin
      if (load) begin
         hold_verts_ff <= canon.verts;
         hold_split_ff <= canon.split;
      end
      corner_a_ff   <= 32'(hold_verts_ff[TET_TAB[hold_split_ff][tet_ff][0]]);
      corner_b_ff   <= 32'(hold_verts_ff[TET_TAB[hold_split_ff][tet_ff][1]]);
      corner_c_ff   <= 32'(hold_verts_ff[TET_TAB[hold_split_ff][tet_ff][2]]);
      corner_d_ff   <= 32'(hold_verts_ff[TET_TAB[hold_split_ff][tet_ff][3]]);
      tet_number_ff <= tet_ff;
      split_case_ff <= hold_split_ff;
      last_tet_ff   <= last_now;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_corner_a   = corner_a_ff;
   assign rsp_corner_b   = corner_b_ff;
   assign rsp_corner_c   = corner_c_ff;
   assign rsp_corner_d   = corner_d_ff;
   assign rsp_tet_number = tet_number_ff;
   assign rsp_split_case = split_case_ff;
   assign rsp_last_tet   = last_tet_ff;

   // tetrahedra of one hexahedron come out in order without gaps
   `ASSERT_PROP(a_tet_seq, clock, reset, strobe_ff && !last_tet_ff |=> strobe_ff && tet_number_ff == tet_idx_type'($past(tet_number_ff) + 3'd1), "tetrahedron sequence broken")
   // split count holds across one hexahedron
   `ASSERT_PROP(a_split_hold, clock, reset, strobe_ff && !last_tet_ff |=> split_case_ff == $past(split_case_ff), "split count changed mid hexahedron")
   // last tetrahedron index matches the split size
   `ASSERT_PROP(a_last_idx, clock, reset, strobe_ff && last_tet_ff |-> (split_case_ff == SPLIT_FIVE && tet_number_ff == LAST_TET_FIVE) || (split_case_ff != SPLIT_FIVE && tet_number_ff == LAST_TET_SIX), "last tetrahedron at wrong index")
   // a new hexahedron starts at tetrahedron zero
   `ASSERT_PROP(a_first_tet, clock, reset, load |=> tet_ff == '0 && hold_valid_ff, "hexahedron load did not restart the count")

endmodule

### rtl/hexahedron_to_tetrahedra_split.sv
// Top level of the hexahedron to tetrahedra conforming split.
// Depends on hts_pkg, hts_minsel, hts_canon and hts_emit.
//
// Each request carries the eight vertex ids of one hexahedron and yields its
// conforming split: five tetrahedra when split_case is 0, six otherwise, one
// tetrahedron per cycle on the rsp_ ports, marked by rsp_strobe and closed by
// rsp_last_tet. The receiver cannot stall, so results must be taken as they
// come. An accepted request passes the request, search and holding registers
// before the result register gives its first tetrahedron. A request is taken
// every cycle while the two input stages have room; in steady state the pace
// is set by the single result port that emits one tetrahedron per cycle, and
// busy is high while both input stages are full behind the busy sequencer.
module hexahedron_to_tetrahedra_split
   import hts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_vert_0,
   input  logic [31:0] req_vert_1,
   input  logic [31:0] req_vert_2,
   input  logic [31:0] req_vert_3,
   input  logic [31:0] req_vert_4,
   input  logic [31:0] req_vert_5,
   input  logic [31:0] req_vert_6,
   input  logic [31:0] req_vert_7,
   output logic        rsp_strobe,
   output logic [31:0] rsp_corner_a,
   output logic [31:0] rsp_corner_b,
   output logic [31:0] rsp_corner_c,
   output logic [31:0] rsp_corner_d,
   output logic [2:0]  rsp_tet_number,
   output logic [1:0]  rsp_split_case,
   output logic        rsp_last_tet
);

   port_hex_type req_verts;
   minsel_type   stage;
   canon_type    canon;
   logic         emit_ready;

   // gather the corner ports into one vector
   assign req_verts = {req_vert_7, req_vert_6, req_vert_5, req_vert_4,
                       req_vert_3, req_vert_2, req_vert_1, req_vert_0};

   hts_minsel u_minsel (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_verts  (req_verts),
      .busy       (busy),
      .down_ready (emit_ready),
      .stage      (stage)
   );

   hts_canon u_canon (
      .stage (stage),
      .canon (canon)
   );

   hts_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage.valid),
      .canon          (canon),
      .in_ready       (emit_ready),
      .rsp_strobe     (rsp_strobe),
      .rsp_corner_a   (rsp_corner_a),
      .rsp_corner_b   (rsp_corner_b),
      .rsp_corner_c   (rsp_corner_c),
      .rsp_corner_d   (rsp_corner_d),
      .rsp_tet_number (rsp_tet_number),
      .rsp_split_case (rsp_split_case),
      .rsp_last_tet   (rsp_last_tet)
   );

endmodule
